// ===== hdl/tsel_pkg.sv =====
// Shared constants and codes for the time-sorted event list.
package tsel_pkg;

	localparam int NODES   = 256;
	localparam int SLOT_W  = $clog2(NODES);
	localparam int PTR_W   = SLOT_W + 1;
	localparam int STAMP_W = 32;

	// Pointer value that marks the end of the list.
	localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(NODES);

	localparam logic [2:0] MODE_ADD    = 3'd0;
	localparam logic [2:0] MODE_ADD_AT = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_MOVE   = 3'd3;
	localparam logic [2:0] MODE_FIND   = 3'd4;

	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_LINKED     = 2'd1;
	localparam logic [1:0] STAT_NOT_LINKED = 2'd2;

endpackage

// ===== hdl/tsel_store.sv =====
// Per-slot storage of time, next and prev with one registered read port.
module tsel_store
	import tsel_pkg::*;
(
	input  logic               clk,
	input  logic               t_we,
	input  logic [SLOT_W-1:0]  t_wa,
	input  logic [STAMP_W-1:0] t_wd,
	input  logic               n_we,
	input  logic [SLOT_W-1:0]  n_wa,
	input  logic [PTR_W-1:0]   n_wd,
	input  logic               p_we,
	input  logic [SLOT_W-1:0]  p_wa,
	input  logic [PTR_W-1:0]   p_wd,
	input  logic [SLOT_W-1:0]  rd_addr,
	output logic [STAMP_W-1:0] rd_time,
	output logic [PTR_W-1:0]   rd_next,
	output logic [PTR_W-1:0]   rd_prev
);

	logic [STAMP_W-1:0] time_mem [NODES];
	logic [PTR_W-1:0]   next_mem [NODES];
	logic [PTR_W-1:0]   prev_mem [NODES];

	// Each field has its own write port; all three are read at one address.
	always_ff @(posedge clk) begin
		if (t_we) begin
			time_mem[t_wa] <= t_wd;
		end
		if (n_we) begin
			next_mem[n_wa] <= n_wd;
		end
		if (p_we) begin
			prev_mem[p_wa] <= p_wd;
		end
		rd_time <= time_mem[rd_addr];
		rd_next <= next_mem[rd_addr];
		rd_prev <= prev_mem[rd_addr];
	end

endmodule

// ===== hdl/time_sorted_event_list_core.sv =====
// Time-sorted event list: sequencer that walks and relinks the slot list.
// Rejected items go straight to the finish state; remove reads the entry and unlinks it;
// add, add-after, find and a relinking move walk the list one entry per cycle through
// the slot memory read port, and a move that keeps its place only rewrites the time.
// One item at a time; busy is high from acceptance until the result strobe.
// Reset empties the list at once; slot memory contents are left undefined.
module time_sorted_event_list_core
	import tsel_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic [7:0]         slot,
	input  logic [31:0]        stamp,
	input  logic [7:0]         start_slot,
	output logic               done,
	output logic [1:0]         status,
	output logic               found,
	output logic [7:0]         found_slot,
	output logic [8:0]         entries
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_TAIL  = 4'd1;
	localparam logic [3:0] ST_TCHK  = 4'd2;
	localparam logic [3:0] ST_WALK  = 4'd3;
	localparam logic [3:0] ST_LINK1 = 4'd4;
	localparam logic [3:0] ST_LINK2 = 4'd5;
	localparam logic [3:0] ST_GET   = 4'd6;
	localparam logic [3:0] ST_MOV2  = 4'd7;
	localparam logic [3:0] ST_MOV3  = 4'd8;
	localparam logic [3:0] ST_UNL   = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	localparam logic [1:0] LK_EMPTY = 2'd0;
	localparam logic [1:0] LK_TAIL  = 2'd1;
	localparam logic [1:0] LK_HEAD  = 2'd2;
	localparam logic [1:0] LK_MID   = 2'd3;

	logic [3:0]         state_q;
	logic [2:0]         mode_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [STAMP_W-1:0] t_q;
	logic [1:0]         status_q;
	logic [PTR_W-1:0]   e_q;
	logic [PTR_W-1:0]   here_q;
	logic [PTR_W-1:0]   p_q;
	logic [PTR_W-1:0]   n_q;
	logic               late_q;
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [PTR_W-1:0]   count_q;
	logic [NODES-1:0]   linked_q;

	logic               done_q;
	logic [1:0]         status_o_q;
	logic               found_q;
	logic [7:0]         found_slot_q;
	logic [8:0]         entries_q;

	logic               t_we, n_we, p_we;
	logic [SLOT_W-1:0]  t_wa, n_wa, p_wa, rd_addr;
	logic [STAMP_W-1:0] t_wd, rd_time;
	logic [PTR_W-1:0]   n_wd, p_wd, rd_next, rd_prev;
	logic [1:0]         link_case;
	logic               accept;
	logic               early;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign early  = (p_q != NONE_PTR) && (t_q < rd_time);

	tsel_store u_store (
		.clk     (clk),
		.t_we    (t_we),
		.t_wa    (t_wa),
		.t_wd    (t_wd),
		.n_we    (n_we),
		.n_wa    (n_wa),
		.n_wd    (n_wd),
		.p_we    (p_we),
		.p_wa    (p_wa),
		.p_wd    (p_wd),
		.rd_addr (rd_addr),
		.rd_time (rd_time),
		.rd_next (rd_next),
		.rd_prev (rd_prev)
	);

	// Where the new entry goes relative to the existing list.
	always_comb begin
		if (count_q == '0) begin
			link_case = LK_EMPTY;
		end else if (here_q == NONE_PTR) begin
			link_case = LK_TAIL;
		end else if (here_q == head_q) begin
			link_case = LK_HEAD;
		end else begin
			link_case = LK_MID;
		end
	end

	// Read address of the slot memory for the entry needed next cycle.
	always_comb begin
		case (state_q)
			ST_IDLE: rd_addr = slot;
			ST_TAIL: rd_addr = tail_q[SLOT_W-1:0];
			ST_TCHK: rd_addr = e_q[SLOT_W-1:0];
			ST_WALK: rd_addr = rd_next[SLOT_W-1:0];
			ST_GET:  rd_addr = rd_next[SLOT_W-1:0];
			ST_MOV2: rd_addr = p_q[SLOT_W-1:0];
			default: rd_addr = '0;
		endcase
	end

	// Memory writes for linking, unlinking and in-place time updates.
	always_comb begin
		t_we = 1'b0;
		t_wa = slot_q;
		t_wd = t_q;
		n_we = 1'b0;
		n_wa = slot_q;
		n_wd = NONE_PTR;
		p_we = 1'b0;
		p_wa = slot_q;
		p_wd = NONE_PTR;
		case (state_q)
			ST_LINK1: begin
				t_we = 1'b1;
				n_we = 1'b1;
				p_we = 1'b1;
				case (link_case)
					LK_TAIL: p_wd = tail_q;
					LK_HEAD: n_wd = head_q;
					LK_MID: begin
						n_wd = here_q;
						p_wd = p_q;
					end
					default: ;
				endcase
			end
			ST_LINK2: begin
				n_wd = PTR_W'(slot_q);
				p_wd = PTR_W'(slot_q);
				case (link_case)
					LK_TAIL: begin
						n_we = 1'b1;
						n_wa = tail_q[SLOT_W-1:0];
					end
					LK_HEAD: begin
						p_we = 1'b1;
						p_wa = head_q[SLOT_W-1:0];
					end
					LK_MID: begin
						n_we = (p_q != NONE_PTR);
						n_wa = p_q[SLOT_W-1:0];
						p_we = 1'b1;
						p_wa = here_q[SLOT_W-1:0];
					end
					default: ;
				endcase
			end
			ST_MOV3: begin
				t_we = !(late_q || early);
			end
			ST_UNL: begin
				n_we = (p_q != NONE_PTR);
				n_wa = p_q[SLOT_W-1:0];
				n_wd = n_q;
				p_we = (n_q != NONE_PTR);
				p_wa = n_q[SLOT_W-1:0];
				p_wd = p_q;
			end
			default: ;
		endcase
	end

	// Sequencer: dispatch, list walk, relink and result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			head_q   <= NONE_PTR;
			tail_q   <= NONE_PTR;
			count_q  <= '0;
			linked_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q   <= mode;
						slot_q   <= slot;
						t_q      <= stamp;
						status_q <= STAT_OK;
						e_q      <= head_q;
						here_q   <= NONE_PTR;
						case (mode)
							MODE_ADD, MODE_ADD_AT: begin
								if (linked_q[slot]) begin
									status_q <= STAT_LINKED;
									state_q  <= ST_FIN;
								end else begin
									if (mode == MODE_ADD_AT && linked_q[start_slot]) begin
										e_q <= PTR_W'(start_slot);
									end
									state_q <= ST_TAIL;
								end
							end
							MODE_REMOVE, MODE_MOVE: begin
								if (!linked_q[slot]) begin
									status_q <= STAT_NOT_LINKED;
									state_q  <= ST_FIN;
								end else begin
									state_q <= ST_GET;
								end
							end
							MODE_FIND: state_q <= ST_TAIL;
							default:   state_q <= ST_FIN;
						endcase
					end
				end
				ST_TAIL: begin
					if (count_q == '0) begin
						here_q  <= NONE_PTR;
						state_q <= (mode_q == MODE_FIND) ? ST_FIN : ST_LINK1;
					end else begin
						state_q <= ST_TCHK;
					end
				end
				ST_TCHK: begin
					if (t_q > rd_time) begin
						here_q  <= NONE_PTR;
						state_q <= (mode_q == MODE_FIND) ? ST_FIN : ST_LINK1;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					// One entry per cycle: stop at the first time not below the new one.
					if (t_q <= rd_time) begin
						here_q  <= e_q;
						p_q     <= rd_prev;
						state_q <= (mode_q == MODE_FIND) ? ST_FIN : ST_LINK1;
					end else if (rd_next == NONE_PTR) begin
						here_q  <= NONE_PTR;
						state_q <= (mode_q == MODE_FIND) ? ST_FIN : ST_LINK1;
					end else begin
						e_q <= rd_next;
					end
				end
				ST_LINK1: state_q <= ST_LINK2;
				ST_LINK2: begin
					case (link_case)
						LK_EMPTY: begin
							head_q <= PTR_W'(slot_q);
							tail_q <= PTR_W'(slot_q);
						end
						LK_TAIL: tail_q <= PTR_W'(slot_q);
						LK_HEAD: head_q <= PTR_W'(slot_q);
						default: ;
					endcase
					linked_q[slot_q] <= 1'b1;
					count_q          <= count_q + 1'b1;
					state_q          <= ST_FIN;
				end
				ST_GET: begin
					p_q     <= rd_prev;
					n_q     <= rd_next;
					state_q <= (mode_q == MODE_MOVE) ? ST_MOV2 : ST_UNL;
				end
				ST_MOV2: begin
					late_q  <= (n_q != NONE_PTR) && (t_q > rd_time);
					state_q <= ST_MOV3;
				end
				ST_MOV3: begin
					state_q <= (late_q || early) ? ST_UNL : ST_FIN;
				end
				ST_UNL: begin
					if (p_q == NONE_PTR) begin
						head_q <= n_q;
						e_q    <= n_q;
					end else begin
						e_q <= head_q;
					end
					if (n_q == NONE_PTR) begin
						tail_q <= p_q;
					end
					linked_q[slot_q] <= 1'b0;
					count_q          <= count_q - 1'b1;
					here_q           <= NONE_PTR;
					state_q          <= (mode_q == MODE_MOVE) ? ST_TAIL : ST_FIN;
				end
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result item registers, loaded as the sequence ends and held until the next result.
	always_ff @(posedge clk) begin
		if (state_q == ST_FIN) begin
			status_o_q   <= status_q;
			found_q      <= (mode_q == MODE_FIND) && (here_q != NONE_PTR);
			found_slot_q <= (mode_q == MODE_FIND) ? here_q[SLOT_W-1:0] : '0;
			entries_q    <= count_q;
		end
	end

	assign done       = done_q;
	assign status     = status_o_q;
	assign found      = found_q;
	assign found_slot = found_slot_q;
	assign entries    = entries_q;

	// Checks on the sequencer and list bookkeeping.
	a_fin_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> done)
		else $error("result strobe missing after finish");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PTR_W'(NODES))
		else $error("entry count out of range");
	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == NONE_PTR && tail_q == NONE_PTR))
		else $error("empty list with head or tail set");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && status != STAT_OK))
		else $error("found with error status");

endmodule
